### rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/nla_pkg.sv
// Package for the nearest landmark association block: default sizes,
// opcodes and the sequencer state type. No dependencies.
package nla_pkg;

   localparam int MAX_MARKS_DEF  = 64;
   localparam int COORD_BITS_DEF = 24;
   localparam int ID_BITS        = 16;

   // Request opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Query sequencer, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIFF = 5'b00010,
      ST_SQX  = 5'b00100,
      ST_SQY  = 5'b01000,
      ST_ACC  = 5'b10000
   } state_type;

endpackage

### rtl/nla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nla_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 64,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/nearest_landmark_association.sv
// Nearest landmark association top level: landmark list and query sequencer.
// Depends on nla_pkg, nla_ram and assert_macros.svh.
//
// Usage:
//   A request is transferred at a rising edge with start high and busy low.
//   req_op selects a load (store a landmark) or a query (find the nearest).
//   A load with req_first set restarts the list; loads into a full list are
//   dropped. A load completes in the transfer cycle, leaves busy low and
//   gives no response.
//   A query against N stored landmarks keeps busy high while each
//   landmark passes through difference, x square, y square and accumulate
//   steps, with the single squaring multiplier used twice per landmark.
//   The response (rsp_valid, rsp_match_id, rsp_found) is shown for exactly
//   one cycle, registered after the last landmark's accumulate step; an empty list answers in
//   the next cycle with rsp_found low and rsp_match_id zero.
//   Ties on squared distance keep the earliest loaded landmark.
//   A new request is not taken while a query is in progress (busy high).
//   The receiver cannot stall; a response is never held back.
//   Reset empties the list and returns the sequencer to idle; the landmark
//   memory itself is not cleared, entries beyond the count are never used.
module nearest_landmark_association #(
   parameter int MAX_MARKS  = nla_pkg::MAX_MARKS_DEF,
   parameter int COORD_BITS = nla_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic                          req_first,
   input  logic signed [COORD_BITS-1:0]  req_pos_x,
   input  logic signed [COORD_BITS-1:0]  req_pos_y,
   input  logic [nla_pkg::ID_BITS-1:0]   req_mark_id,
   output logic                          rsp_valid,
   output logic [nla_pkg::ID_BITS-1:0]   rsp_match_id,
   output logic                          rsp_found
);

   import nla_pkg::*;

   localparam int CW  = $clog2(MAX_MARKS + 1);
   localparam int AW  = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
   localparam int RW  = 2 * COORD_BITS + ID_BITS;
   localparam int SQW = 2 * COORD_BITS;

   state_type                    state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in;
   logic signed [COORD_BITS-1:0] py_ff, py_in;
   logic [COORD_BITS-1:0]        dx_ff, dx_in;
   logic [COORD_BITS-1:0]        dy_ff, dy_in;
   logic [SQW-1:0]               sqx_ff, sqx_in;
   logic [SQW-1:0]               sqy_ff, sqy_in;
   logic [SQW:0]                 best_ff, best_in;
   logic [ID_BITS-1:0]           best_id_ff, best_id_in;
   logic [ID_BITS-1:0]           cand_id_ff, cand_id_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]           rsp_id_ff, rsp_id_in;
   logic                         rsp_found_ff, rsp_found_in;

   logic                         accept;
   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [RW-1:0]                ram_wdata;
   logic                         ram_re;
   logic [AW-1:0]                ram_raddr;
   logic [RW-1:0]                ram_rdata;

   logic signed [COORD_BITS-1:0] mx, my;
   logic [ID_BITS-1:0]           mid;
   logic signed [COORD_BITS:0]   diff_x, diff_y;
   logic [COORD_BITS:0]          mag_x, mag_y;
   logic [COORD_BITS-1:0]        mul_op;
   logic [SQW-1:0]               mul_prod;
   logic [SQW:0]                 dist_sum;
   logic [CW-1:0]                idx_next;
   logic                         last;
   logic                         take;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Landmark memory: {x, y, id} per entry
   nla_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_MARKS),
      .ADDR_BITS (AW)
   ) u_mark_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ram_we    = accept && (req_op == OP_LOAD) &&
                      (req_first || (count_ff < CW'(MAX_MARKS)));
   assign ram_waddr = req_first ? AW'(0) : count_ff[AW-1:0];
   assign ram_wdata = {req_pos_x, req_pos_y, req_mark_id};

   assign mx  = ram_rdata[RW-1 -: COORD_BITS];
   assign my  = ram_rdata[ID_BITS +: COORD_BITS];
   assign mid = ram_rdata[ID_BITS-1:0];

   assign idx_next = idx_ff + CW'(1);
   assign last     = (idx_next == count_ff);

   // First read on query transfer, next entry fetched during the y square
   assign ram_re    = (accept && (req_op == OP_QUERY)) || ((state_ff == ST_SQY) && !last);
   assign ram_raddr = (state_ff == ST_SQY) ? idx_next[AW-1:0] : AW'(0);

   // Absolute coordinate differences
   assign diff_x = {px_ff[COORD_BITS-1], px_ff} - {mx[COORD_BITS-1], mx};
   assign diff_y = {py_ff[COORD_BITS-1], py_ff} - {my[COORD_BITS-1], my};
   assign mag_x  = diff_x[COORD_BITS] ? (COORD_BITS+1)'(-diff_x) : diff_x;
   assign mag_y  = diff_y[COORD_BITS] ? (COORD_BITS+1)'(-diff_y) : diff_y;

   // Shared squaring multiplier
   assign mul_op   = (state_ff == ST_SQX) ? dx_ff : dy_ff;
   assign mul_prod = SQW'(mul_op) * SQW'(mul_op);

   // Distance sum and running best compare; first entry always taken
   assign dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign take     = (idx_ff == CW'(0)) || (dist_sum < best_ff);

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      best_in      = best_ff;
      best_id_in   = best_id_ff;
      cand_id_in   = cand_id_ff;
      rsp_valid_in = 1'b0;
      rsp_id_in    = rsp_id_ff;
      rsp_found_in = rsp_found_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_LOAD)) begin
               if (req_first) begin
                  count_in = CW'(1);
               end else if (count_ff < CW'(MAX_MARKS)) begin
                  count_in = count_ff + CW'(1);
               end
            end else if (accept) begin
               px_in  = req_pos_x;
               py_in  = req_pos_y;
               idx_in = CW'(0);
               if (count_ff == CW'(0)) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = '0;
                  rsp_found_in = 1'b0;
               end else begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            dx_in      = mag_x[COORD_BITS-1:0];
            dy_in      = mag_y[COORD_BITS-1:0];
            cand_id_in = mid;
            state_in   = ST_SQX;
         end
         ST_SQX: begin
            sqx_in   = mul_prod;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sqy_in   = mul_prod;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (take) begin
               best_in    = dist_sum;
               best_id_in = cand_id_ff;
            end
            if (last) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = take ? cand_id_ff : best_id_ff;
               rsp_found_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in   = idx_next;
               state_in = ST_DIFF;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      best_ff      <= best_in;
      best_id_ff   <= best_id_in;
      cand_id_ff   <= cand_id_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_match_id = rsp_id_ff;
   assign rsp_found    = rsp_found_ff;

   // Checks
   `include "assert_macros.svh"

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_MARKS))
   `ASSERT_IMPLIES(a_scan_in_range, clock, reset, busy, idx_ff < count_ff)
   `ASSERT_NEXT(a_rsp_on_last, clock, reset, (state_ff == ST_ACC) && last, rsp_valid && rsp_found)
   `ASSERT_IMPLIES(a_none_is_zero, clock, reset, rsp_valid && !rsp_found, rsp_match_id == '0)

endmodule

### tb/tb_nearest_landmark_association.sv
// Testbench for nearest_landmark_association: checks each query response against
// a local nearest-neighbor predictor under random start gaps. Depends on nla_pkg.
module tb_nearest_landmark_association;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB  = nla_pkg::COORD_BITS_DEF;
   localparam int MM  = nla_pkg::MAX_MARKS_DEF;
   localparam int IDW = nla_pkg::ID_BITS;

   localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};

   // coordinate spreads for random landmarks and query points
   localparam int SPREAD_FULL   = 0;
   localparam int SPREAD_GRID   = 1;
   localparam int SPREAD_CORNER = 2;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 4 * MM + 16;

   typedef struct {
      logic                 op;
      logic                 first;
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic [IDW-1:0]       id;
   } mark_req_t;

   typedef struct {
      logic [IDW-1:0] id;
      logic           found;
   } match_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_op = nla_pkg::OP_LOAD;
   logic                 req_first = 1'b0;
   logic signed [CB-1:0] req_pos_x = '0;
   logic signed [CB-1:0] req_pos_y = '0;
   logic [IDW-1:0]       req_mark_id = '0;
   logic                 rsp_valid;
   logic [IDW-1:0]       rsp_match_id;
   logic                 rsp_found;

   nearest_landmark_association #(
      .MAX_MARKS  (MM),
      .COORD_BITS (CB)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_first    (req_first),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_mark_id  (req_mark_id),
      .rsp_valid    (rsp_valid),
      .rsp_match_id (rsp_match_id),
      .rsp_found    (rsp_found)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the landmark list
   logic signed [CB-1:0] lm_x [MM];
   logic signed [CB-1:0] lm_y [MM];
   logic [IDW-1:0]       lm_id [MM];
   int unsigned          lm_count = 0;

   mark_req_t pending_reqs[$];
   match_t    expected_matches[$];

   int   sender_idle_pct = 31;
   logic took_item = 1'b0;
   int   quiet_cycles = 0;

   int error_count = 0;
   int load_count = 0;
   int dropped_loads = 0;
   int query_count = 0;
   int empty_queries = 0;
   int full_queries = 0;
   int tied_queries = 0;
   int matches_checked = 0;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // append a landmark; a set first flag restarts the list
   task automatic store_landmark(input logic fst, input logic signed [CB-1:0] x,
                                 input logic signed [CB-1:0] y, input logic [IDW-1:0] id);
      load_count++;
      if (fst)
         lm_count = 0;
      if (lm_count < MM) begin
         lm_x[lm_count]  = x;
         lm_y[lm_count]  = y;
         lm_id[lm_count] = id;
         lm_count++;
      end else begin
         dropped_loads++;
      end
   endtask

   // exact squared distance; strict less-than keeps the earliest on a tie
   function automatic match_t nearest_match(input logic signed [CB-1:0] qx,
                                            input logic signed [CB-1:0] qy,
                                            output logic tied);
      match_t m;
      longint dx, dy, sq_dist, best;
      m.id = '0;
      m.found = 1'b0;
      best = 0;
      tied = 1'b0;
      for (int i = 0; i < lm_count; i++) begin
         dx = longint'(qx) - longint'(lm_x[i]);
         dy = longint'(qy) - longint'(lm_y[i]);
         sq_dist = dx * dx + dy * dy;
         if (!m.found || sq_dist < best) begin
            m.found = 1'b1;
            m.id = lm_id[i];
            best = sq_dist;
            tied = 1'b0;
         end else if (sq_dist == best) begin
            tied = 1'b1;
         end
      end
      return m;
   endfunction

   task automatic push_item(input logic op, input logic fst, input logic signed [CB-1:0] x,
                            input logic signed [CB-1:0] y, input logic [IDW-1:0] id);
      mark_req_t it;
      it.op = op;
      it.first = fst;
      it.x = x;
      it.y = y;
      it.id = id;
      pending_reqs = {pending_reqs, it};
   endtask

   function automatic logic signed [CB-1:0] pick_coord(input int spread);
      logic signed [CB-1:0] c;
      int g;
      case (spread)
         SPREAD_FULL: c = CB'($urandom);
         SPREAD_GRID: begin
            g = int'($urandom_range(0, 8)) - 4;
            c = CB'(g * 256);
         end
         default: begin
            case ($urandom_range(0, 5))
               0: c = COORD_MAX;
               1: c = COORD_MIN;
               2: c = COORD_MAX - 1;
               3: c = COORD_MIN + 1;
               4: c = '0;
               default: c = '1;
            endcase
         end
      endcase
      return c;
   endfunction

   // extremes, ties, restart, duplicate positions, query on the empty list
   task automatic build_directed();
      push_item(nla_pkg::OP_QUERY, 1'b0, COORD_MAX, COORD_MIN, 16'hFFFF);
      push_item(nla_pkg::OP_LOAD,  1'b1, COORD_MAX, COORD_MAX, 16'hFFFF);
      push_item(nla_pkg::OP_LOAD,  1'b0, COORD_MIN, COORD_MIN, 16'h0000);
      push_item(nla_pkg::OP_QUERY, 1'b0, COORD_MIN, COORD_MIN, 16'h0000);
      push_item(nla_pkg::OP_QUERY, 1'b0, COORD_MAX, COORD_MAX, 16'h0000);
      push_item(nla_pkg::OP_QUERY, 1'b0, COORD_MAX, COORD_MIN, 16'h0000);
      push_item(nla_pkg::OP_QUERY, 1'b0, '0, '0, 16'h0000);
      push_item(nla_pkg::OP_QUERY, 1'b0, '1, '1, 16'h0000);
      push_item(nla_pkg::OP_LOAD,  1'b1, '0, '0, 16'h1234);
      push_item(nla_pkg::OP_LOAD,  1'b0, CB'(256), '0, 16'h00A5);
      push_item(nla_pkg::OP_LOAD,  1'b0, CB'(-256), '0, 16'h5A00);
      push_item(nla_pkg::OP_QUERY, 1'b1, '0, '0, 16'hFFFF);
      push_item(nla_pkg::OP_QUERY, 1'b0, CB'(128), '0, 16'h0000);
      push_item(nla_pkg::OP_QUERY, 1'b0, CB'(-128), '0, 16'h0000);
      push_item(nla_pkg::OP_QUERY, 1'b0, CB'(200), CB'(5), 16'h0000);
      push_item(nla_pkg::OP_QUERY, 1'b0, CB'(-300), CB'(-7), 16'h0000);
      push_item(nla_pkg::OP_LOAD,  1'b1, CB'(5), CB'(5), 16'h0007);
      push_item(nla_pkg::OP_LOAD,  1'b0, CB'(5), CB'(5), 16'h0008);
      push_item(nla_pkg::OP_QUERY, 1'b0, CB'(5), CB'(5), 16'h0000);
      push_item(nla_pkg::OP_QUERY, 1'b0, COORD_MIN, COORD_MAX, 16'h0000);
      push_item(nla_pkg::OP_LOAD,  1'b0, COORD_MIN, COORD_MAX, 16'hFFFF);
      push_item(nla_pkg::OP_QUERY, 1'b0, COORD_MIN, COORD_MAX, 16'h0000);
   endtask

   // mostly restart + loads + queries; a few overfill the list; some append, the rest is noise
   task automatic build_random(input int target);
      int added, roll, spread, nmarks, nq;
      added = 0;
      while (added < target) begin
         roll = $urandom_range(0, 99);
         spread = $urandom_range(SPREAD_FULL, SPREAD_CORNER);
         if (roll < 80) begin
            nmarks = ($urandom_range(0, 24) == 0) ? $urandom_range(MM - 4, MM + 6)
                                                  : $urandom_range(1, 8);
            for (int k = 0; k < nmarks; k++)
               push_item(nla_pkg::OP_LOAD, k == 0, pick_coord(spread), pick_coord(spread),
                         IDW'($urandom));
            nq = $urandom_range(1, 5);
            for (int k = 0; k < nq; k++)
               push_item(nla_pkg::OP_QUERY, 1'($urandom), pick_coord(spread),
                         pick_coord(spread), IDW'($urandom));
            added += nmarks + nq;
         end else if (roll < 90) begin
            // appends to whatever list is there, then one query
            nmarks = $urandom_range(1, 4);
            for (int k = 0; k < nmarks; k++)
               push_item(nla_pkg::OP_LOAD, 1'b0, pick_coord(spread), pick_coord(spread),
                         IDW'($urandom));
            push_item(nla_pkg::OP_QUERY, 1'b0, pick_coord(spread), pick_coord(spread),
                      IDW'($urandom));
            added += nmarks + 1;
         end else begin
            push_item(1'($urandom), 1'($urandom), pick_coord(SPREAD_FULL),
                      pick_coord(SPREAD_FULL), IDW'($urandom));
            added++;
         end
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || start || expected_matches.size() != 0)
         @(posedge clock);
   endtask

   // driver: new transfer at the falling edge once the previous one was taken
   always @(negedge clock) begin
      mark_req_t nxt;
      logic go;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took_item) begin
         go = (pending_reqs.size() != 0) && ($urandom_range(0, 99) >= sender_idle_pct);
         if (go) begin
            nxt = pending_reqs.pop_front();
            start       <= 1'b1;
            req_op      <= nxt.op;
            req_first   <= nxt.first;
            req_pos_x   <= nxt.x;
            req_pos_y   <= nxt.y;
            req_mark_id <= nxt.id;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check responses first, then predict from the accepted request
   always @(posedge clock) begin
      match_t want, got;
      logic tied;
      if (reset) begin
         took_item <= 1'b0;
      end else begin
         if (rsp_valid) begin
            got.id = rsp_match_id;
            got.found = rsp_found;
            if (expected_matches.size() == 0) begin
               report_mismatch($sformatf("response id=%h found=%b with no query outstanding",
                                         got.id, got.found));
            end else begin
               want = expected_matches.pop_front();
               matches_checked++;
               if (got.found !== want.found)
                  report_mismatch($sformatf("found=%b, expected %b", got.found, want.found));
               if (got.id !== want.id)
                  report_mismatch($sformatf("match_id=%h, expected %h", got.id, want.id));
            end
         end
         took_item <= start && !busy;
         if (start && !busy) begin
            if (req_op == nla_pkg::OP_LOAD) begin
               store_landmark(req_first, req_pos_x, req_pos_y, req_mark_id);
            end else begin
               query_count++;
               if (lm_count == 0)
                  empty_queries++;
               if (lm_count == MM)
                  full_queries++;
               want = nearest_match(req_pos_x, req_pos_y, tied);
               if (tied)
                  tied_queries++;
               expected_matches = {expected_matches, want};
            end
         end
      end
   end

   // watchdog on cycles without any transfer or response
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_nearest_landmark_association: errors");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender gaps about a third of the time
      sender_idle_pct = 31;
      build_directed();
      build_random(530);
      drain();

      // sender mostly idle
      sender_idle_pct = 73;
      build_random(550);
      drain();

      // back to back
      sender_idle_pct = 0;
      build_random(550);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d loads (%0d dropped on a full list) and %0d queries, %0d checked",
               load_count, dropped_loads, query_count, matches_checked);
      $display("queries: %0d on an empty list, %0d on a full list, %0d with a distance tie",
               empty_queries, full_queries, tied_queries);
      if (error_count == 0 && expected_matches.size() == 0) begin
         $display("tb_nearest_landmark_association: clean");
      end else begin
         $display("tb_nearest_landmark_association: errors");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/nla_pkg.sv
rtl/nla_ram.sv
rtl/nearest_landmark_association.sv
tb/tb_nearest_landmark_association.sv
